>>> src/pir_pkg.sv
// Shared constants for the permuted index remap block.
// Used by the channel interfaces, the divide pipeline and the top level.
`default_nettype none
package pir_pkg;
  localparam int MAX_DIMS        = 7;
  localparam int SIZE_BITS       = 16;
  localparam int DIM_BITS        = 3;
  localparam int ORDER_BITS      = MAX_DIMS * DIM_BITS;
  localparam int CFG_IDX_BITS    = 4;
  localparam int STEPS_PER_STAGE = 4;

  localparam int NUM_DIMS_DEF    = 7;
  localparam int INDEX_BITS_DEF  = 32;
  localparam int DATA_BITS_DEF   = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM0     = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STORAGE_ORDER = 4'd7;
  localparam logic [ORDER_BITS-1:0]   ORDER_RESET       = 21'd1754760;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [DIM_BITS-1:0]  dim_t;
endpackage
`default_nettype wire

>>> src/pir_in_if.sv
// Input request channel: source index and element bits.
// Depends on pir_pkg for default widths.
`default_nettype none
interface pir_in_if import pir_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] source_index;
  logic [DATA_BITS-1:0]  element_bits;
  modport source (output valid, source_index, element_bits, input ready);
  modport sink   (input valid, source_index, element_bits, output ready);
endinterface
`default_nettype wire

>>> src/pir_out_if.sv
// Result request channel: destination index, element bits and range flag.
// Depends on pir_pkg for default widths.
`default_nettype none
interface pir_out_if import pir_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] dest_index;
  logic [DATA_BITS-1:0]  element_out;
  logic                  index_beyond_count;
  modport source (output valid, dest_index, element_out, index_beyond_count, input ready);
  modport sink   (input valid, dest_index, element_out, index_beyond_count, output ready);
endinterface
`default_nettype wire

>>> src/pir_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pir_pkg for the field widths.
`default_nettype none
interface pir_cfg_if import pir_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [ORDER_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/pir_divpipe.sv
// Pipelined mixed-radix splitter: restoring division, four quotient bits a stage.
// Depends on pir_pkg; divisors and slot dimensions come from the top level.
`default_nettype none
module pir_divpipe import pir_pkg::*; #(
  parameter int NUM_DIMS   = NUM_DIMS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [MAX_DIMS-1:0][DIM_BITS-1:0]   slot_dim,
  input  wire logic [MAX_DIMS-1:0][SIZE_BITS-1:0]  slot_div,
  input  wire logic                                i_valid,
  output      logic                                i_ready,
  input  wire logic [INDEX_BITS-1:0]               i_src,
  input  wire logic [DATA_BITS-1:0]                i_data,
  output      logic                                o_valid,
  input  wire logic                                o_ready,
  output      logic [INDEX_BITS-1:0]               o_src,
  output      logic [DATA_BITS-1:0]                o_data,
  output      logic [MAX_DIMS-1:0][SIZE_BITS-1:0]  o_subs
);
  localparam int TOTAL = NUM_DIMS * INDEX_BITS;
  localparam int NSTG  = (TOTAL + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic                               v_r    [NSTG];
  logic [INDEX_BITS-1:0]              num_r  [NSTG];
  logic [SIZE_BITS-1:0]               rem_r  [NSTG];
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] subs_r [NSTG];
  logic [INDEX_BITS-1:0]              src_r  [NSTG];
  logic [DATA_BITS-1:0]               data_r [NSTG];
  logic                               rdy    [NSTG+1];

  assign rdy[NSTG] = o_ready;
  assign i_ready   = rdy[0];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic                               cv;
    logic [INDEX_BITS-1:0]              csrc;
    logic [DATA_BITS-1:0]               cdata;
    logic [INDEX_BITS-1:0]              cn [STEPS_PER_STAGE+1];
    logic [SIZE_BITS-1:0]               cr [STEPS_PER_STAGE+1];
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0] cs [STEPS_PER_STAGE+1];

    assign rdy[s] = !v_r[s] || rdy[s+1];

    if (s == 0) begin : g_head
      assign cv    = i_valid;
      assign csrc  = i_src;
      assign cdata = i_data;
      assign cn[0] = i_src;
      assign cr[0] = '0;
      assign cs[0] = '0;
    end else begin : g_body
      assign cv    = v_r[s-1];
      assign csrc  = src_r[s-1];
      assign cdata = data_r[s-1];
      assign cn[0] = num_r[s-1];
      assign cr[0] = rem_r[s-1];
      assign cs[0] = subs_r[s-1];
    end

    for (genvar j = 0; j < STEPS_PER_STAGE; j++) begin : g_step
      localparam int G = s * STEPS_PER_STAGE + j;
      if (G < TOTAL) begin : g_live
        localparam int K     = G / INDEX_BITS;
        localparam bit LAST  = (G % INDEX_BITS) == (INDEX_BITS - 1);
        logic [SIZE_BITS:0] sh;
        logic [SIZE_BITS:0] dv;
        logic [SIZE_BITS:0] r2;
        logic               ge;
        always_comb begin
          sh = {cr[j], cn[j][INDEX_BITS-1]};
          dv = {1'b0, slot_div[K]};
          ge = sh >= dv;
          r2 = ge ? sh - dv : sh;
          cn[j+1] = {cn[j][INDEX_BITS-2:0], ge};
          cs[j+1] = cs[j];
          if (LAST) begin
            // End of one digit: the remainder is the subscript, the quotient divides on.
            cr[j+1] = '0;
            if ({1'b0, slot_dim[K]} < (DIM_BITS+1)'(NUM_DIMS)) begin
              cs[j+1][slot_dim[K]] = r2[SIZE_BITS-1:0];
            end
          end else begin
            cr[j+1] = r2[SIZE_BITS-1:0];
          end
        end
      end else begin : g_idle
        assign cn[j+1] = cn[j];
        assign cr[j+1] = cr[j];
        assign cs[j+1] = cs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        num_r[s]  <= cn[STEPS_PER_STAGE];
        rem_r[s]  <= cr[STEPS_PER_STAGE];
        subs_r[s] <= cs[STEPS_PER_STAGE];
        src_r[s]  <= csrc;
        data_r[s] <= cdata;
      end
    end
  end

  assign o_valid = v_r[NSTG-1];
  assign o_src   = src_r[NSTG-1];
  assign o_data  = data_r[NSTG-1];
  assign o_subs  = subs_r[NSTG-1];
endmodule
`default_nettype wire

>>> src/permuted_index_remap_unit.sv
// Top level of the permuted index remap block: configuration registers,
// stride and count chains, and the recombine stages. Uses pir_pkg,
// the three channel interfaces and pir_divpipe.
//
// Usage: each request on in_chan carries a source linear index and the raw
// element bits. The index is split into subscripts in the configured storage
// order, fastest dimension first, and recombined with column-major strides.
// One result leaves on out_chan for each request, in order, with the element
// bits unchanged and a flag when the index is at or beyond the element count.
// The divide pipeline resolves four quotient bits per stage, then one multiply
// stage, two adder stages and the output register follow.
// Throughput is one request per cycle while out_chan is ready. Each stage
// holds its own valid bit, so a stalled receiver only freezes the stages that
// are full; bubbles ahead of the stall still close up and new requests are
// taken until the pipe is full.
// cfg_chan is always ready. The stride and count registers settle after a
// write, well inside the latency of the divide pipeline.
// Reset clears the pipeline and sets every size to 1 and the identity order.
`default_nettype none
module permuted_index_remap_unit import pir_pkg::*; #(
  parameter int NUM_DIMS   = NUM_DIMS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int DATA_BITS  = DATA_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pir_in_if.sink     in_chan,
  pir_out_if.source  out_chan,
  pir_cfg_if.sink    cfg_chan
);
  localparam int DIM_CODES = 2 ** DIM_BITS;

  size_t                 size_r  [MAX_DIMS];
  logic [ORDER_BITS-1:0] order_r;
  size_t                 eff_tab [DIM_CODES];
  logic [INDEX_BITS-1:0] stride_r [MAX_DIMS];
  logic [INDEX_BITS:0]   cnt_r    [MAX_DIMS+1];

  logic [MAX_DIMS-1:0][DIM_BITS-1:0]  slot_dim;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] slot_div;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        size_r[d] <= size_t'(1);
      end
      order_r <= ORDER_RESET;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index < REG_STORAGE_ORDER) begin
        size_r[DIM_BITS'(cfg_chan.index - REG_SIZE_DIM0)] <= cfg_chan.data[SIZE_BITS-1:0];
      end else if (cfg_chan.index == REG_STORAGE_ORDER) begin
        order_r <= cfg_chan.data;
      end
    end
  end

  // Effective size by dimension code; unused and zero sizes act as 1.
  always_comb begin
    for (int d = 0; d < DIM_CODES; d++) begin
      eff_tab[d] = size_t'(1);
      if (d < NUM_DIMS && d < MAX_DIMS) begin
        if (size_r[d] != '0) begin
          eff_tab[d] = size_r[d];
        end
      end
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      slot_dim[k] = order_r[k*DIM_BITS +: DIM_BITS];
      slot_div[k] = eff_tab[slot_dim[k]];
    end
  end

  // Stride and saturating count chains, one multiply per link.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        stride_r[d] <= INDEX_BITS'(1);
      end
      for (int d = 0; d <= MAX_DIMS; d++) begin
        cnt_r[d] <= (INDEX_BITS+1)'(1);
      end
    end else begin
      stride_r[0] <= INDEX_BITS'(1);
      cnt_r[0]    <= (INDEX_BITS+1)'(1);
      for (int d = 1; d < MAX_DIMS; d++) begin
        stride_r[d] <= INDEX_BITS'({16'd0, stride_r[d-1]} *
                                   {{INDEX_BITS{1'b0}}, eff_tab[d-1]});
      end
      for (int d = 1; d <= MAX_DIMS; d++) begin
        logic [INDEX_BITS+SIZE_BITS:0] prod;
        prod = {16'd0, cnt_r[d-1]} * {{(INDEX_BITS+1){1'b0}}, eff_tab[d-1]};
        if (prod > (INDEX_BITS+SIZE_BITS+1)'(1) << INDEX_BITS) begin
          cnt_r[d] <= (INDEX_BITS+1)'(1) << INDEX_BITS;
        end else begin
          cnt_r[d] <= prod[INDEX_BITS:0];
        end
      end
    end
  end

  // Divide pipeline.
  logic                               dp_valid;
  logic                               dp_ready;
  logic [INDEX_BITS-1:0]              dp_src;
  logic [DATA_BITS-1:0]               dp_data;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] dp_subs;

  pir_divpipe #(
    .NUM_DIMS  (NUM_DIMS),
    .INDEX_BITS(INDEX_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_divpipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .slot_dim(slot_dim),
    .slot_div(slot_div),
    .i_valid (in_chan.valid),
    .i_ready (in_chan.ready),
    .i_src   (in_chan.source_index),
    .i_data  (in_chan.element_bits),
    .o_valid (dp_valid),
    .o_ready (dp_ready),
    .o_src   (dp_src),
    .o_data  (dp_data),
    .o_subs  (dp_subs)
  );

  // Recombine: products, two adder levels, output register.
  logic                  pm_v_r, pa_v_r, pb_v_r, out_v_r;
  logic [INDEX_BITS-1:0] pm_prod_r [MAX_DIMS];
  logic [INDEX_BITS-1:0] pa_sum_r  [4];
  logic [INDEX_BITS-1:0] pb_sum_r  [2];
  logic                  pm_bey_r, pa_bey_r, pb_bey_r, out_bey_r;
  logic [DATA_BITS-1:0]  pm_data_r, pa_data_r, pb_data_r, out_data_r;
  logic [INDEX_BITS-1:0] out_dest_r;
  logic                  rdy_out, rdy_b, rdy_a, rdy_m;

  assign rdy_out  = !out_v_r || out_chan.ready;
  assign rdy_b    = !pb_v_r || rdy_out;
  assign rdy_a    = !pa_v_r || rdy_b;
  assign rdy_m    = !pm_v_r || rdy_a;
  assign dp_ready = rdy_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r  <= 1'b0;
      pa_v_r  <= 1'b0;
      pb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_m) begin
        pm_v_r <= dp_valid;
      end
      if (rdy_a) begin
        pa_v_r <= pm_v_r;
      end
      if (rdy_b) begin
        pb_v_r <= pa_v_r;
      end
      if (rdy_out) begin
        out_v_r <= pb_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        pm_prod_r[d] <= INDEX_BITS'({{INDEX_BITS{1'b0}}, dp_subs[d]} *
                                    {16'd0, stride_r[d]});
      end
      pm_bey_r  <= {1'b0, dp_src} >= cnt_r[MAX_DIMS];
      pm_data_r <= dp_data;
    end
    if (rdy_a) begin
      pa_sum_r[0] <= pm_prod_r[0] + pm_prod_r[1];
      pa_sum_r[1] <= pm_prod_r[2] + pm_prod_r[3];
      pa_sum_r[2] <= pm_prod_r[4] + pm_prod_r[5];
      pa_sum_r[3] <= pm_prod_r[6];
      pa_bey_r    <= pm_bey_r;
      pa_data_r   <= pm_data_r;
    end
    if (rdy_b) begin
      pb_sum_r[0] <= pa_sum_r[0] + pa_sum_r[1];
      pb_sum_r[1] <= pa_sum_r[2] + pa_sum_r[3];
      pb_bey_r    <= pa_bey_r;
      pb_data_r   <= pa_data_r;
    end
    if (rdy_out) begin
      out_dest_r <= pb_bey_r ? '0 : pb_sum_r[0] + pb_sum_r[1];
      out_bey_r  <= pb_bey_r;
      out_data_r <= pb_data_r;
    end
  end

  assign out_chan.valid              = out_v_r;
  assign out_chan.dest_index         = out_dest_r;
  assign out_chan.element_out        = out_data_r;
  assign out_chan.index_beyond_count = out_bey_r;
endmodule
`default_nettype wire
